// File: rtl/iirs_pkg.sv
`default_nettype none

package iirs_pkg;

	// Store geometry.
	localparam int CAPACITY = 64;
	localparam int WORD_W = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Request and result field widths.
	localparam int OP_W = 3;
	localparam int POS_W = 7;
	localparam int COUNT_FIELD_W = 7;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// The top entry is read through a two-level registered tree of groups.
	localparam int GRP_W = (IDX_W < 3) ? IDX_W : 3;
	localparam int GRP_SIZE = 1 << GRP_W;
	localparam int NGRP = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
	localparam int HI_W = (IDX_W - GRP_W > 0) ? IDX_W - GRP_W : 1;

	// Word shown for top and bottom while the store is empty.
	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_POP = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic signed [POS_W:0] position;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [COUNT_FIELD_W-1:0] entry_count;
		logic signed [WORD_W-1:0] top_value;
		logic signed [WORD_W-1:0] bottom_value;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ins;
		logic del;
		logic [IDX_W-1:0] slot;
		logic rd_grp;
		logic rd_out;
		logic [CNT_W-1:0] count;
		status_t status;
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/indexed_insert_remove_stack.sv
// Bounded stack of 64 signed 32-bit entries, counted from the bottom, with
// push, pop, insert at a position, remove at a position and clear. Every
// request word gives exactly one result word with status, count, and the top
// and bottom entries (all ones when empty). A request passes three steps
// from acceptance to a loaded result: the whole cell row shifts on
// acceptance, then the registered two-level read takes the top entry out
// of the row, its last level waiting while an earlier result is held back.
// One request is in work at a time; a new one is accepted once the last
// result is loaded, even while that result waits in the result register.
// Entries above the count are never read and need no reset.
`default_nettype none

module indexed_insert_remove_stack (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_stall,
	input  wire iirs_pkg::req_t req,
	output logic rsp_valid,
	input  wire logic rsp_stall,
	output iirs_pkg::rsp_t rsp
);

	iirs_pkg::cmd_t cmd;

	// Request decode and sequencing.
	iirs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd(cmd)
	);

	// Cell row, top read tree and result register.
	iirs_dpath u_dpath (
		.clk(clk),
		.cmd(cmd),
		.word(req.value),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

// File: rtl/iirs_dpath.sv
`default_nettype none

module iirs_dpath (
	input  wire logic clk,
	input  wire iirs_pkg::cmd_t cmd,
	input  wire logic [iirs_pkg::WORD_W-1:0] word,
	output iirs_pkg::rsp_t rsp
);

	logic [iirs_pkg::WORD_W-1:0] cells_q [iirs_pkg::CAPACITY];
	logic [iirs_pkg::WORD_W-1:0] pad_c [iirs_pkg::NGRP][iirs_pkg::GRP_SIZE];
	logic [iirs_pkg::WORD_W-1:0] grp_q [iirs_pkg::NGRP];
	logic [iirs_pkg::IDX_W-1:0] rd_idx;
	logic [iirs_pkg::GRP_W-1:0] rd_lo;
	logic [iirs_pkg::HI_W-1:0] rd_hi;
	logic empty;
	iirs_pkg::rsp_t rsp_q;

	// Row of cells: an insert moves every cell above the slot up by one,
	// a remove moves every cell at and above the slot down by one.
	for (genvar j = 0; j < iirs_pkg::CAPACITY; j++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (iirs_pkg::IDX_W'(j) == cmd.slot) begin
					cells_q[j] <= word;
				end else if (iirs_pkg::IDX_W'(j) > cmd.slot) begin
					if (j > 0) begin
						cells_q[j] <= cells_q[(j > 0) ? j - 1 : 0];
					end
				end
			end else if (cmd.del) begin
				if (iirs_pkg::IDX_W'(j) >= cmd.slot) begin
					if (j < iirs_pkg::CAPACITY - 1) begin
						cells_q[j] <= cells_q[(j < iirs_pkg::CAPACITY - 1) ? j + 1 : j];
					end
				end
			end
		end
	end

	// The top entry sits one below the count.
	assign rd_idx = iirs_pkg::IDX_W'(cmd.count - iirs_pkg::CNT_W'(1));
	assign rd_lo = rd_idx[iirs_pkg::GRP_W-1:0];
	assign rd_hi = iirs_pkg::HI_W'(rd_idx >> iirs_pkg::GRP_W);
	assign empty = (cmd.count == '0);

	// Cells arranged in groups; slots past the capacity read as zero.
	always_comb begin
		for (int g = 0; g < iirs_pkg::NGRP; g++) begin
			for (int k = 0; k < iirs_pkg::GRP_SIZE; k++) begin
				if (g * iirs_pkg::GRP_SIZE + k < iirs_pkg::CAPACITY) begin
					pad_c[g][k] = cells_q[g * iirs_pkg::GRP_SIZE + k];
				end else begin
					pad_c[g][k] = '0;
				end
			end
		end
	end

	// First level of the top read: one pick inside every group.
	always_ff @(posedge clk) begin
		if (cmd.rd_grp) begin
			for (int g = 0; g < iirs_pkg::NGRP; g++) begin
				grp_q[g] <= pad_c[g][rd_lo];
			end
		end
	end

	// Second level: pick the group and load the result word.
	always_ff @(posedge clk) begin
		if (cmd.rd_out) begin
			rsp_q.status <= cmd.status;
			rsp_q.entry_count <= iirs_pkg::COUNT_FIELD_W'(cmd.count);
			rsp_q.top_value <= empty ? iirs_pkg::EMPTY_WORD : grp_q[rd_hi];
			rsp_q.bottom_value <= empty ? iirs_pkg::EMPTY_WORD : cells_q[0];
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// File: rtl/iirs_ctrl.sv
`default_nettype none

module iirs_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_stall,
	input  wire iirs_pkg::req_t req,
	output logic rsp_valid,
	input  wire logic rsp_stall,
	output iirs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD1 = 3'b010,
		S_RD2 = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [iirs_pkg::CNT_W-1:0] count_q, count_c;
	iirs_pkg::status_t status_q, status_c;
	logic valid_q;
	logic accept;
	logic ins_c, del_c;
	logic [iirs_pkg::IDX_W-1:0] slot_c;
	logic neg, full, empty, past_top;
	logic [iirs_pkg::POS_W-1:0] pos;

	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;

	assign neg = req.position[iirs_pkg::POS_W];
	assign pos = req.position[iirs_pkg::POS_W-1:0];
	assign full = (count_q == iirs_pkg::CNT_W'(iirs_pkg::CAPACITY));
	assign empty = (count_q == '0);
	assign past_top = (iirs_pkg::CMP_W'(pos) >= iirs_pkg::CMP_W'(count_q));

	// Decode the request into a cell move, a new count and a status.
	always_comb begin
		ins_c = 1'b0;
		del_c = 1'b0;
		slot_c = iirs_pkg::IDX_W'(count_q);
		status_c = iirs_pkg::ST_DONE;
		count_c = count_q;
		unique case (req.operation)
			iirs_pkg::OP_PUSH: begin
				if (full) begin
					status_c = iirs_pkg::ST_FULL;
				end else begin
					ins_c = 1'b1;
					count_c = count_q + iirs_pkg::CNT_W'(1);
				end
			end
			iirs_pkg::OP_POP: begin
				if (empty) begin
					status_c = iirs_pkg::ST_EMPTY;
				end else begin
					count_c = count_q - iirs_pkg::CNT_W'(1);
				end
			end
			iirs_pkg::OP_INSERT: begin
				if (neg) begin
					status_c = iirs_pkg::ST_BADPOS;
				end else if (full) begin
					status_c = iirs_pkg::ST_FULL;
				end else begin
					ins_c = 1'b1;
					if (!past_top) begin
						slot_c = iirs_pkg::IDX_W'(pos);
					end
					count_c = count_q + iirs_pkg::CNT_W'(1);
				end
			end
			iirs_pkg::OP_REMOVE: begin
				if (neg) begin
					status_c = iirs_pkg::ST_BADPOS;
				end else if (empty) begin
					status_c = iirs_pkg::ST_EMPTY;
				end else if (count_q == iirs_pkg::CNT_W'(1)) begin
					count_c = '0;
				end else if (past_top) begin
					status_c = iirs_pkg::ST_BADPOS;
				end else begin
					del_c = 1'b1;
					slot_c = iirs_pkg::IDX_W'(pos);
					count_c = count_q - iirs_pkg::CNT_W'(1);
				end
			end
			iirs_pkg::OP_CLEAR: begin
				count_c = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: accept, read the group level, then load the result word.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RD1;
				end
			end
			S_RD1: begin
				state_d = S_RD2;
			end
			S_RD2: begin
				if (cmd.rd_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			status_q <= iirs_pkg::ST_DONE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= count_c;
				status_q <= status_c;
			end
			if (cmd.rd_out) begin
				valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.ins = accept && ins_c;
		cmd.del = accept && del_c;
		cmd.slot = slot_c;
		cmd.rd_grp = (state_q == S_RD1);
		cmd.rd_out = (state_q == S_RD2) && (!valid_q || !rsp_stall);
		cmd.count = count_q;
		cmd.status = status_q;
	end

	assign rsp_valid = valid_q;

	// The count never runs past the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= iirs_pkg::CNT_W'(iirs_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	// An accepted word always starts the read sequence.
	a_accept_rd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_RD1))
		else $error("accepted word did not start a read");

	// A result word is never loaded over one that waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_out |-> (!valid_q || !rsp_stall))
		else $error("result word overwritten");

	// Only one cell move at a time, and only on acceptance.
	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins || cmd.del) |-> (accept && !(cmd.ins && cmd.del)))
		else $error("bad cell move command");

	// The count changes only on acceptance.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q))
		else $error("count changed outside acceptance");

endmodule

`default_nettype wire

// File: dv/tb_indexed_insert_remove_stack.sv
module tb_indexed_insert_remove_stack;
	import iirs_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_CLEAR + 1'b1;
	localparam logic [OP_W-1:0] OP_SPARE_LAST = '1;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [POS_W:0] POS_MAX = 8'sd127;
	localparam logic signed [POS_W:0] POS_MIN = -8'sd128;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS = 40;
	localparam int RUN_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	indexed_insert_remove_stack uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted store contents, bottom at index zero.
	logic signed [WORD_W-1:0] stack_words [CAPACITY];
	int stack_depth = 0;
	rsp_t pending_results [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	bit growing = 1'b1;

	// Applies one request to the predicted store and returns the result word it gives.
	function automatic rsp_t predict_stack_result(req_t w);
		rsp_t r;
		bit negative;
		int slot;
		int i;
		r = '0;
		r.status = ST_DONE;
		negative = w.position[POS_W];
		slot = int'(w.position[POS_W-1:0]);
		case (w.operation)
			OP_PUSH: begin
				if (stack_depth >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					stack_words[stack_depth] = w.value;
					stack_depth++;
				end
			end
			OP_POP: begin
				if (stack_depth == 0) r.status = ST_EMPTY;
				else stack_depth--;
			end
			OP_INSERT: begin
				if (negative) begin
					r.status = ST_BADPOS;
				end else if (stack_depth >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (slot >= stack_depth) begin
					stack_words[stack_depth] = w.value;
					stack_depth++;
				end else begin
					for (i = stack_depth; i > slot; i--) stack_words[i] = stack_words[i-1];
					stack_words[slot] = w.value;
					stack_depth++;
				end
			end
			OP_REMOVE: begin
				if (negative) begin
					r.status = ST_BADPOS;
				end else if (stack_depth == 0) begin
					r.status = ST_EMPTY;
				end else if (stack_depth == 1) begin
					stack_depth = 0;
				end else if (slot >= stack_depth) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = slot; i + 1 < stack_depth; i++) stack_words[i] = stack_words[i+1];
					stack_depth--;
				end
			end
			OP_CLEAR: begin
				stack_depth = 0;
			end
			default: begin
			end
		endcase
		r.entry_count = COUNT_FIELD_W'(stack_depth);
		if (stack_depth == 0) begin
			r.top_value = EMPTY_WORD;
			r.bottom_value = EMPTY_WORD;
		end else begin
			r.top_value = stack_words[stack_depth-1];
			r.bottom_value = stack_words[0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, what);
	endtask

	// The receiver stalls at random at the rate of the current test.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	// Each accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word arrived with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						rsp.entry_count, want.entry_count));
				if (rsp.top_value !== want.top_value)
					report_mismatch($sformatf("top_value %h, expected %h",
						rsp.top_value, want.top_value));
				if (rsp.bottom_value !== want.bottom_value)
					report_mismatch($sformatf("bottom_value %h, expected %h",
						rsp.bottom_value, want.bottom_value));
			end
		end
	end

	// Sends one request word, idling first at the sender rate of the current test.
	task automatic send_word(req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		pending_results.push_back(predict_stack_result(w));
	endtask

	task automatic send_op(logic [OP_W-1:0] op, logic signed [POS_W:0] pos,
		logic signed [WORD_W-1:0] val);
		req_t w;
		w.operation = op;
		w.position = pos;
		w.value = val;
		send_word(w);
	endtask

	// Holds the sender off until every expected result word has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Random request biased to fill the store to capacity and then drain it.
	function automatic req_t random_request();
		req_t w;
		int pick;
		int where;
		if (stack_depth >= CAPACITY && $urandom_range(99) < 25) growing = 1'b0;
		if (stack_depth == 0 && $urandom_range(99) < 50) growing = 1'b1;
		pick = $urandom_range(99);
		if (growing) begin
			if (pick < 40) w.operation = OP_PUSH;
			else if (pick < 75) w.operation = OP_INSERT;
			else if (pick < 85) w.operation = OP_POP;
			else if (pick < 97) w.operation = OP_REMOVE;
			else w.operation = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end else begin
			if (pick < 12) w.operation = OP_PUSH;
			else if (pick < 22) w.operation = OP_INSERT;
			else if (pick < 52) w.operation = OP_POP;
			else if (pick < 92) w.operation = OP_REMOVE;
			else if (pick < 96) w.operation = OP_CLEAR;
			else w.operation = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		// Positions are mostly near the current count, with some negative or far off.
		where = $urandom_range(99);
		if (where < 8) w.position = (POS_W + 1)'($urandom_range(128, 255));
		else if (where < 16) w.position = (POS_W + 1)'($urandom_range(0, 127));
		else w.position = (POS_W + 1)'($urandom_range(0, stack_depth + 1));
		case ($urandom_range(39))
			0: w.value = WORD_MAX;
			1: w.value = WORD_MIN;
			2: w.value = '0;
			3: w.value = '1;
			default: w.value = $urandom;
		endcase
		return w;
	endfunction

	task automatic send_random_words(int count);
		for (int n = 0; n < count; n++) send_word(random_request());
	endtask

	// Empty store, bad positions, shifts in both directions, spare codes and clear.
	task automatic test_corner_cases();
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		send_op(OP_POP, 8'sd0, '0);
		send_op(OP_REMOVE, 8'sd0, '0);
		send_op(OP_REMOVE, -8'sd1, '0);
		send_op(OP_INSERT, POS_MIN, WORD_MAX);
		send_op(OP_INSERT, POS_MAX, WORD_MAX);
		send_op(OP_REMOVE, POS_MAX, '0);
		send_op(OP_PUSH, POS_MAX, WORD_MIN);
		send_op(OP_PUSH, POS_MIN, '1);
		send_op(OP_INSERT, 8'sd0, '0);
		send_op(OP_INSERT, 8'sd1, 32'sh1234_5678);
		send_op(OP_INSERT, 8'sd4, 32'sh5a5a_5a5a);
		send_op(OP_REMOVE, 8'sd5, '0);
		send_op(OP_REMOVE, POS_MAX, '0);
		send_op(OP_REMOVE, 8'sd0, '0);
		send_op(OP_REMOVE, 8'sd2, '0);
		send_op(OP_POP, POS_MIN, '0);
		send_op(OP_SPARE_FIRST, POS_MAX, 32'sh0f0f_0f0f);
		send_op(OP_SPARE_FIRST + 1'b1, POS_MIN, WORD_MIN);
		send_op(OP_SPARE_LAST, -8'sd1, '1);
		send_op(OP_REMOVE, POS_MIN, '0);
		send_op(OP_CLEAR, POS_MAX, '1);
		send_op(OP_CLEAR, 8'sd0, '0);
		send_op(OP_PUSH, 8'sd0, 32'shaaaa_aaaa);
		send_op(OP_POP, 8'sd0, '0);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		send_random_words(200);
		wait_drained();
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 54;
		rcv_stall_pct = 0;
		send_random_words(200);
		wait_drained();
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		rcv_stall_pct = 54;
		send_random_words(200);
		wait_drained();
	endtask

	task automatic test_both_sides_idle();
		send_idle_pct = 36;
		rcv_stall_pct = 36;
		send_random_words(200);
		wait_drained();
	endtask

	// Bursts separated by full drains of the result path.
	task automatic test_pause_until_drained();
		send_idle_pct = 0;
		rcv_stall_pct = 54;
		for (int burst = 0; burst < 6; burst++) begin
			send_random_words($urandom_range(10, 20));
			wait_drained();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_sides_idle();
		test_pause_until_drained();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin
		#RUN_LIMIT;
		$display("Mismatches found");
		$finish;
	end

endmodule
